// ----- rtl/stpd_pkg.sv -----
// Package for the socket table port demultiplexer: request codes, constants,
// slot record type and controller state type. No dependencies.
package stpd_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int RING_DEPTH_DEF = 8;

  localparam logic [2:0] REQ_ALLOC   = 3'd0;
  localparam logic [2:0] REQ_FREE    = 3'd1;
  localparam logic [2:0] REQ_LOOKUP  = 3'd2;
  localparam logic [2:0] REQ_BIND    = 3'd3;
  localparam logic [2:0] REQ_DELIVER = 3'd4;
  localparam logic [2:0] REQ_COUNT   = 3'd5;

  localparam logic [3:0] KIND_DGRAM    = 4'd2;
  localparam logic [1:0] STATE_CREATED = 2'd1;
  localparam logic [15:0] LEN_CLIP     = 16'd512;

  localparam int IN_W  = 112;
  localparam int OUT_W = 56;

  typedef struct packed {
    logic [7:0]  domain;
    logic [3:0]  kind;
    logic [7:0]  protocol;
    logic [1:0]  status;
    logic [15:0] port;
    logic [6:0]  fill;
    logic [5:0]  tail;
  } slot_rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_SCAN,
    ST_OUT
  } ctl_state_t;

endpackage

// ----- rtl/socket_table_port_demux_core.sv -----
// Top level of the socket table port demultiplexer: slot record memory,
// used-bit register file, datagram header ring memory and request sequencer.
// Depends on stpd_pkg.
//
// Allocate, free, lookup and bind pass through the read, execute and output steps;
// count and deliver pass through the read, scan and output steps. Deliver scans one
// slot per cycle and stops at the first match or the last slot. One request is in
// flight at a time, and the next input beat can be taken in the cycle after the result beat is accepted.
// The slot record memory's single read port sets the deliver scan rate. Synchronous
// active-low reset clears the used bits and the control state; no clearing pass exists.
module socket_table_port_demux_core #(
  parameter int SLOT_COUNT = stpd_pkg::SLOT_COUNT_DEF,
  parameter int RING_DEPTH = stpd_pkg::RING_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // req_type[2:0], fd[10:3], domain[18:11], sock_kind[22:19], protocol[30:23],
  // port[46:31], src_ip[78:47], sender_port[94:79], length[110:95], zero pad
  input  logic [stpd_pkg::IN_W-1:0] in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // status[0], fd_out[5:1], active_count[10:6], entry_domain[18:11],
  // entry_kind[22:19], entry_protocol[30:23], entry_status[32:31],
  // entry_port[48:33], entry_queued[52:49], zero pad
  output logic [stpd_pkg::OUT_W-1:0] out_tdata
);
  import stpd_pkg::*;

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int QD = SLOT_COUNT * RING_DEPTH;
  localparam int QW = (QD > 1) ? $clog2(QD) : 1;

  // Held request fields.
  logic [2:0]  req_r;
  logic [7:0]  fd_r, dom_r, prot_r;
  logic [3:0]  kind_r;
  logic [15:0] port_r, sport_r, len_r;
  logic [31:0] sip_r;

  ctl_state_t  st_r, st_nxt;
  logic [SLOT_COUNT-1:0] used_r;
  logic [SW-1:0] idx_r;          // slot being read or scanned
  logic [OUT_W-1:0] res_r;

  // Slot record memory, one read and one write port, registered read.
  slot_rec_t rec_mem [SLOT_COUNT];
  slot_rec_t rd_r;
  logic      we;
  logic [SW-1:0] wa;
  slot_rec_t wd;
  logic [SW-1:0] ra;

  // Header rings; only written, never read by any request.
  logic [57:0] q_mem [QD];
  logic        qwe;
  logic [QW-1:0] qwa;
  logic [57:0] qwd;

  always_ff @(posedge clk) begin
    if (we) rec_mem[wa] <= wd;
    rd_r <= rec_mem[ra];
    if (qwe) q_mem[qwa] <= qwd;
  end

  logic fd_ok;
  assign fd_ok = (fd_r != 8'd0) && ({24'd0, fd_r} <= 32'(SLOT_COUNT));

  logic last;
  assign last = ({{(32-SW){1'b0}}, idx_r} == 32'(SLOT_COUNT - 1));

  // Match of the record read last cycle (slot idx_r) for deliver.
  logic dmatch;
  assign dmatch = used_r[idx_r] && rd_r.kind == KIND_DGRAM && rd_r.port == port_r
                  && {25'd0, rd_r.fill} < 32'(RING_DEPTH);

  logic [SW-1:0] free_idx;
  logic          free_any;
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = SW'(i);
        free_any = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_tvalid) st_nxt = ST_READ;
      ST_READ: st_nxt = (req_r == REQ_DELIVER || req_r == REQ_COUNT) ? ST_SCAN : ST_EXEC;
      ST_EXEC: st_nxt = ST_OUT;
      ST_SCAN: begin
        if (req_r == REQ_COUNT || last || dmatch) st_nxt = ST_OUT;
      end
      ST_OUT:  if (out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Memory controls.
  slot_rec_t upd;
  always_comb begin
    in_tready = (st_r == ST_IDLE);
    out_tvalid = (st_r == ST_OUT);
    out_tdata = res_r;
    ra = idx_r;
    if (st_r == ST_SCAN && !last) ra = idx_r + 1'b1;
    we = 1'b0;
    wa = idx_r;
    wd = rd_r;
    upd = rd_r;
    qwe = 1'b0;
    qwa = QW'({{(32-SW){1'b0}}, idx_r} * RING_DEPTH + {26'd0, rd_r.tail});
    qwd = {sip_r, sport_r, (len_r > LEN_CLIP) ? LEN_CLIP[9:0] : len_r[9:0]};
    upd.port = port_r;
    if (st_r == ST_EXEC && req_r == REQ_ALLOC) begin
      we = free_any;
      wa = free_idx;
      wd = '{domain: dom_r, kind: kind_r, protocol: prot_r, status: STATE_CREATED,
             port: 16'd0, fill: 7'd0, tail: 6'd0};
    end
    if (st_r == ST_EXEC && req_r == REQ_BIND && fd_ok && used_r[idx_r]) begin
      we = 1'b1;
      wd = upd;
    end
    if (st_r == ST_SCAN && req_r == REQ_DELIVER && dmatch) begin
      we = 1'b1;
      qwe = 1'b1;
      wd = rd_r;
      wd.fill = rd_r.fill + 7'd1;
      wd.tail = ({26'd0, rd_r.tail} == 32'(RING_DEPTH - 1)) ? 6'd0 : rd_r.tail + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      used_r <= '0;
      idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            req_r <= in_tdata[2:0];
            fd_r <= in_tdata[10:3];
            dom_r <= in_tdata[18:11];
            kind_r <= in_tdata[22:19];
            prot_r <= in_tdata[30:23];
            port_r <= in_tdata[46:31];
            sip_r <= in_tdata[78:47];
            sport_r <= in_tdata[94:79];
            len_r <= in_tdata[110:95];
            idx_r <= (in_tdata[2:0] == REQ_DELIVER || in_tdata[2:0] == REQ_COUNT)
                     ? '0 : SW'(in_tdata[10:3] - 8'd1);
          end
        end
        ST_READ: begin
          res_r <= OUT_W'(1);
        end
        ST_EXEC: begin
          case (req_r)
            REQ_ALLOC: if (free_any) begin
              used_r[free_idx] <= 1'b1;
              res_r <= OUT_W'({5'(free_idx) + 5'd1, 1'b0});
            end
            REQ_FREE: if (fd_ok && used_r[idx_r]) begin
              used_r[idx_r] <= 1'b0;
              res_r <= OUT_W'(0);
            end
            REQ_LOOKUP: if (fd_ok && used_r[idx_r]) begin
              res_r <= OUT_W'({rd_r.fill[3:0], rd_r.port, rd_r.status, rd_r.protocol,
                               rd_r.kind, rd_r.domain, 5'd0, 5'd0, 1'b0});
            end
            REQ_BIND: if (fd_ok && used_r[idx_r]) res_r <= OUT_W'(0);
            default: res_r <= OUT_W'(1);
          endcase
        end
        ST_SCAN: begin
          if (req_r == REQ_COUNT) begin
            res_r <= OUT_W'({5'($countones(used_r)), 5'd0, 1'b0});
          end else if (dmatch) begin
            res_r <= OUT_W'({5'(idx_r) + 5'd1, 1'b0});
          end else if (!last) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // The result is never offered while a request is still being taken.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input and output both open");
  // A successful allocate marks exactly one more slot used.
  a_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EXEC && req_r == REQ_ALLOC && free_any) |=>
    $countones(used_r) == $countones($past(used_r)) + 1) else $error("alloc count");
  // A result beat follows only from the execute or scan step.
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(st_r) == ST_EXEC || $past(st_r) == ST_SCAN))
    else $error("bad result entry");

endmodule
